FILE: rtl/asrc_pkg.sv
// ----------------------------------------------------------------------------
// asrc_pkg
// Shared types, constants and the CRC-8 byte update for the reading checker.
// ----------------------------------------------------------------------------
package asrc_pkg;

    localparam logic [7:0] CRC_POLY      = 8'h31;
    localparam logic [7:0] CRC_INIT      = 8'hFF;
    localparam logic [7:0] CRC_TOP       = 8'h80;
    localparam logic [7:0] WARM_UP_RESET = 8'd16;
    localparam int         WORDS_PER_READING_DEF = 2;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_BYTE    = 2'd2,
        CMD_BUS_ERR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_WARM_UP = 2'd1,
        ST_FAILED  = 2'd2
    } status_t;

    // byte within the current word
    typedef enum logic [1:0] {
        BP_HIGH = 2'd0,
        BP_LOW  = 2'd1,
        BP_CRC  = 2'd2
    } byte_pos_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] rx_byte;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] co2_eq;
        logic [15:0] tvoc;
    } rsp_t;

    // one processed transaction from the frame checker
    typedef struct packed {
        logic emit;
        rsp_t rsp;
    } step_t;

    // msb-first crc-8 update over one byte, no final xor
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 8'h00)
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/asrc_in_stage.sv
// ----------------------------------------------------------------------------
// asrc_in_stage
// Input register: holds one transaction until the frame checker takes it.
// ----------------------------------------------------------------------------
module asrc_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  asrc_pkg::req_t  req,
    input  logic            advance,
    output logic            held_valid,
    output asrc_pkg::req_t  held
);

    logic           valid_reg;
    logic           valid_next;
    asrc_pkg::req_t data_reg;
    logic           load;

    assign req_ready  = !valid_reg || advance;
    assign load       = req_valid && req_ready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= req;
    end

    assign held_valid = valid_reg;
    assign held       = data_reg;

endmodule

FILE: rtl/asrc_frame.sv
// ----------------------------------------------------------------------------
// asrc_frame
// Frame state and per-transaction decode: warm-up count, byte/word position,
// running CRC and captured words.
// ----------------------------------------------------------------------------
module asrc_frame #(
    parameter int WORDS_PER_READING = asrc_pkg::WORDS_PER_READING_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      warm_up_ticks,
    input  asrc_pkg::req_t  req,
    input  logic            step_en,
    output asrc_pkg::step_t step
);

    localparam int WPW = (WORDS_PER_READING > 1) ? $clog2(WORDS_PER_READING) : 1;
    localparam logic [WPW-1:0] LAST_WORD   = WPW'(WORDS_PER_READING - 1);
    localparam logic [WPW-1:0] SECOND_WORD = WPW'(1);

    logic [7:0]          warm_left_reg,   warm_left_next;
    asrc_pkg::byte_pos_t byte_pos_reg,    byte_pos_next;
    logic [WPW-1:0]      word_pos_reg,    word_pos_next;
    logic [7:0]          crc_reg,         crc_next;
    logic                crc_good_reg,    crc_good_next;
    logic [7:0]          high_byte_reg,   high_byte_next;
    logic [15:0]         first_word_reg,  first_word_next;
    logic [15:0]         second_word_reg, second_word_next;
    logic [7:0]          crc_upd;
    logic                good;
    logic [15:0]         tvoc_word;

    assign crc_upd   = asrc_pkg::crc8_byte(crc_reg, req.rx_byte);
    assign good      = crc_good_reg && (req.rx_byte == crc_reg);
    assign tvoc_word = (WORDS_PER_READING >= 2) ? second_word_reg : 16'h0000;

    always_comb
    begin
        warm_left_next   = warm_left_reg;
        byte_pos_next    = byte_pos_reg;
        word_pos_next    = word_pos_reg;
        crc_next         = crc_reg;
        crc_good_next    = crc_good_reg;
        high_byte_next   = high_byte_reg;
        first_word_next  = first_word_reg;
        second_word_next = second_word_reg;
        step.emit        = 1'b0;
        step.rsp.status  = asrc_pkg::ST_FAILED;
        step.rsp.co2_eq  = 16'h0000;
        step.rsp.tvoc    = 16'h0000;

        case (req.cmd)
            asrc_pkg::CMD_START:
            begin
                warm_left_next = warm_up_ticks;
                byte_pos_next  = asrc_pkg::BP_HIGH;
                word_pos_next  = '0;
                crc_next       = asrc_pkg::CRC_INIT;
                crc_good_next  = 1'b1;
            end
            asrc_pkg::CMD_TICK:
            begin
                byte_pos_next = asrc_pkg::BP_HIGH;
                word_pos_next = '0;
                crc_next      = asrc_pkg::CRC_INIT;
                crc_good_next = 1'b1;
                if (warm_left_reg != 8'd0)
                begin
                    warm_left_next  = warm_left_reg - 8'd1;
                    step.emit       = 1'b1;
                    step.rsp.status = asrc_pkg::ST_WARM_UP;
                end
            end
            asrc_pkg::CMD_BUS_ERR:
            begin
                byte_pos_next   = asrc_pkg::BP_HIGH;
                word_pos_next   = '0;
                crc_next        = asrc_pkg::CRC_INIT;
                crc_good_next   = 1'b1;
                step.emit       = 1'b1;
                step.rsp.status = asrc_pkg::ST_FAILED;
            end
            default:
            begin
                case (byte_pos_reg)
                    asrc_pkg::BP_HIGH:
                    begin
                        high_byte_next = req.rx_byte;
                        crc_next       = crc_upd;
                        byte_pos_next  = asrc_pkg::BP_LOW;
                    end
                    asrc_pkg::BP_LOW:
                    begin
                        crc_next      = crc_upd;
                        byte_pos_next = asrc_pkg::BP_CRC;
                        if (word_pos_reg == '0)
                            first_word_next = {high_byte_reg, req.rx_byte};
                        else if (word_pos_reg == SECOND_WORD)
                            second_word_next = {high_byte_reg, req.rx_byte};
                    end
                    default:
                    begin
                        // crc byte closes the word
                        byte_pos_next = asrc_pkg::BP_HIGH;
                        crc_next      = asrc_pkg::CRC_INIT;
                        if (word_pos_reg == LAST_WORD)
                        begin
                            word_pos_next = '0;
                            crc_good_next = 1'b1;
                            step.emit     = 1'b1;
                            if (good)
                            begin
                                step.rsp.status = asrc_pkg::ST_VALID;
                                step.rsp.co2_eq = first_word_reg;
                                step.rsp.tvoc   = tvoc_word;
                            end
                        end
                        else
                        begin
                            word_pos_next = word_pos_reg + WPW'(1);
                            crc_good_next = good;
                        end
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_left_reg   <= 8'd0;
            byte_pos_reg    <= asrc_pkg::BP_HIGH;
            word_pos_reg    <= '0;
            crc_reg         <= asrc_pkg::CRC_INIT;
            crc_good_reg    <= 1'b1;
            high_byte_reg   <= 8'd0;
            first_word_reg  <= 16'h0000;
            second_word_reg <= 16'h0000;
        end
        else if (step_en)
        begin
            warm_left_reg   <= warm_left_next;
            byte_pos_reg    <= byte_pos_next;
            word_pos_reg    <= word_pos_next;
            crc_reg         <= crc_next;
            crc_good_reg    <= crc_good_next;
            high_byte_reg   <= high_byte_next;
            first_word_reg  <= first_word_next;
            second_word_reg <= second_word_next;
        end
    end

endmodule

FILE: rtl/asrc_out_stage.sv
// ----------------------------------------------------------------------------
// asrc_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module asrc_out_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  asrc_pkg::rsp_t  rsp_in,
    output logic            busy,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output asrc_pkg::rsp_t  rsp
);

    logic           valid_reg;
    logic           valid_next;
    asrc_pkg::rsp_t data_reg;

    assign busy       = valid_reg && !rsp_ready;
    assign valid_next = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= rsp_in;
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule

FILE: rtl/air_sensor_reading_checker_core.sv
// path: an accepted transaction is held in the input register, and its result is
// then loaded into the result register, which drives rsp_valid
// throughput: one transaction per cycle; a transaction that emits stalls only
// while the result register still holds a result that was not taken
// the crc byte update is an unrolled eight-step shift network between the registers
// reset: rst_n clears both stages, warm-up count 0, crc 0xFF, register to 16
// ----------------------------------------------------------------------------
// air_sensor_reading_checker_core
// Checks CRC-8 protected word frames of a gas sensor reading and reports
// valid, warm-up or failed results.
// ----------------------------------------------------------------------------
module air_sensor_reading_checker_core #(
    parameter int WORDS_PER_READING = asrc_pkg::WORDS_PER_READING_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [7:0]      cfg_wdata,
    input  logic            req_valid,
    output logic            req_ready,
    input  asrc_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output asrc_pkg::rsp_t  rsp
);

    logic [7:0]      warm_cfg_reg;
    logic            held_valid;
    asrc_pkg::req_t  held;
    asrc_pkg::step_t step;
    logic            out_busy;
    logic            advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            warm_cfg_reg <= asrc_pkg::WARM_UP_RESET;
        else if (cfg_we)
            warm_cfg_reg <= cfg_wdata;
    end

    // a transaction that emits nothing never waits on the result register
    assign advance = held_valid && (!step.emit || !out_busy);

    asrc_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .advance    (advance),
        .held_valid (held_valid),
        .held       (held)
    );

    asrc_frame #(
        .WORDS_PER_READING (WORDS_PER_READING)
    ) u_frame
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .warm_up_ticks (warm_cfg_reg),
        .req           (held),
        .step_en       (advance),
        .step          (step)
    );

    asrc_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && step.emit),
        .rsp_in    (step.rsp),
        .busy      (out_busy),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
